>>> rtl/core/cmvm_pkg.sv
// Shared types and constants for the complex matrix-vector mixer.
// No dependencies; every other file of the block imports this package.
package cmvm_pkg;

	localparam int NUM_CH    = 4;
	localparam int SAMPLE_W  = 16;
	localparam int PROD_W    = 2 * SAMPLE_W;
	// Eight products of 32 bits, combined in pairs, summed over four columns
	localparam int ACC_W     = PROD_W + 3;
	localparam int NUM_REGS  = 2 * NUM_CH;
	localparam int REG_W     = NUM_CH * SAMPLE_W;
	localparam int CFG_IDX_W = 4;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	typedef struct packed {
		sample_t re;
		sample_t im;
	} cplx_t;

	typedef cplx_t [NUM_CH-1:0] cvec_t;

	typedef logic [NUM_REGS-1:0][REG_W-1:0] coef_bank_t;

	// Load enables of the pipeline stages behind the input register
	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
	} pipe_en_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ROW0_RE = 4'd0,
		CFG_ROW0_IM = 4'd1,
		CFG_ROW1_RE = 4'd2,
		CFG_ROW1_IM = 4'd3,
		CFG_ROW2_RE = 4'd4,
		CFG_ROW2_IM = 4'd5,
		CFG_ROW3_RE = 4'd6,
		CFG_ROW3_IM = 4'd7
	} cfg_idx_t;

	// Identity matrix in Q1.14 after reset
	localparam logic [REG_W-1:0] RST_ROW0_RE = 64'h0000_0000_0000_4000;
	localparam logic [REG_W-1:0] RST_ROW1_RE = 64'h0000_0000_4000_0000;
	localparam logic [REG_W-1:0] RST_ROW2_RE = 64'h0000_4000_0000_0000;
	localparam logic [REG_W-1:0] RST_ROW3_RE = 64'h4000_0000_0000_0000;
	localparam logic [REG_W-1:0] RST_IMAG    = 64'h0;

	localparam logic signed [ACC_W:0] SAT_HI = (ACC_W+1)'(32767);
	localparam logic signed [ACC_W:0] SAT_LO = -SAT_HI - (ACC_W+1)'(1);

endpackage

>>> rtl/core/cmvm_if.sv
// Stream interfaces of the mixer: sample vector in, result vector out.
// Depends on cmvm_pkg for the sample type.
interface cmvm_in_if import cmvm_pkg::*; ();
	logic    valid;
	logic    ready;
	sample_t x0_re;
	sample_t x0_im;
	sample_t x1_re;
	sample_t x1_im;
	sample_t x2_re;
	sample_t x2_im;
	sample_t x3_re;
	sample_t x3_im;
	logic    block_end;

	modport source (output valid, x0_re, x0_im, x1_re, x1_im, x2_re, x2_im, x3_re, x3_im,
		block_end, input ready);
	modport sink (input valid, x0_re, x0_im, x1_re, x1_im, x2_re, x2_im, x3_re, x3_im,
		block_end, output ready);
	modport mon (input valid, ready, x0_re, x0_im, x1_re, x1_im, x2_re, x2_im, x3_re, x3_im,
		block_end);
endinterface

interface cmvm_out_if import cmvm_pkg::*; ();
	logic    valid;
	logic    ready;
	sample_t y0_re;
	sample_t y0_im;
	sample_t y1_re;
	sample_t y1_im;
	sample_t y2_re;
	sample_t y2_im;
	sample_t y3_re;
	sample_t y3_im;
	logic    block_end_out;

	modport source (output valid, y0_re, y0_im, y1_re, y1_im, y2_re, y2_im, y3_re, y3_im,
		block_end_out, input ready);
	modport sink (input valid, y0_re, y0_im, y1_re, y1_im, y2_re, y2_im, y3_re, y3_im,
		block_end_out, output ready);
	modport mon (input valid, ready, y0_re, y0_im, y1_re, y1_im, y2_re, y2_im, y3_re, y3_im,
		block_end_out);
endinterface

>>> rtl/core/cmvm_coef_bank.sv
// Coefficient register file: eight 64-bit rows of packed Q1.14 values.
// Depends on cmvm_pkg.
module cmvm_coef_bank import cmvm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [REG_W-1:0]     cfg_wdata,
	output coef_bank_t           coef
);

	coef_bank_t coef_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q[CFG_ROW0_RE] <= RST_ROW0_RE;
			coef_q[CFG_ROW0_IM] <= RST_IMAG;
			coef_q[CFG_ROW1_RE] <= RST_ROW1_RE;
			coef_q[CFG_ROW1_IM] <= RST_IMAG;
			coef_q[CFG_ROW2_RE] <= RST_ROW2_RE;
			coef_q[CFG_ROW2_IM] <= RST_IMAG;
			coef_q[CFG_ROW3_RE] <= RST_ROW3_RE;
			coef_q[CFG_ROW3_IM] <= RST_IMAG;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ROW0_RE: coef_q[CFG_ROW0_RE] <= cfg_wdata;
				CFG_ROW0_IM: coef_q[CFG_ROW0_IM] <= cfg_wdata;
				CFG_ROW1_RE: coef_q[CFG_ROW1_RE] <= cfg_wdata;
				CFG_ROW1_IM: coef_q[CFG_ROW1_IM] <= cfg_wdata;
				CFG_ROW2_RE: coef_q[CFG_ROW2_RE] <= cfg_wdata;
				CFG_ROW2_IM: coef_q[CFG_ROW2_IM] <= cfg_wdata;
				CFG_ROW3_RE: coef_q[CFG_ROW3_RE] <= cfg_wdata;
				CFG_ROW3_IM: coef_q[CFG_ROW3_IM] <= cfg_wdata;
				default: ; // drop writes beyond the register list
			endcase
		end
	end

	assign coef = coef_q;

endmodule

>>> rtl/core/cmvm_row.sv
// One output row: products, row sum, then round and saturate to 16 bits.
// Depends on cmvm_pkg.
module cmvm_row import cmvm_pkg::*; #(
	parameter int NUM_IN         = 4,
	parameter int COEF_FRAC_BITS = 14
) (
	input  logic             clk,
	input  pipe_en_t         en,
	input  cvec_t            x_s1,
	input  logic [REG_W-1:0] coef_re,
	input  logic [REG_W-1:0] coef_im,
	output sample_t          y_re_s4,
	output sample_t          y_im_s4
);

	localparam logic signed [ACC_W:0] RND = (ACC_W+1)'(1) << (COEF_FRAC_BITS - 1);

	logic signed [PROD_W-1:0] prr_s2 [NUM_IN];
	logic signed [PROD_W-1:0] pii_s2 [NUM_IN];
	logic signed [PROD_W-1:0] pri_s2 [NUM_IN];
	logic signed [PROD_W-1:0] pir_s2 [NUM_IN];

	logic signed [ACC_W-1:0] acc_re;
	logic signed [ACC_W-1:0] acc_im;
	logic signed [ACC_W-1:0] sum_re_s3;
	logic signed [ACC_W-1:0] sum_im_s3;

	// Add half an LSB, floor-shift, clamp to the 16-bit range
	function automatic sample_t rnd_sat(input logic signed [ACC_W-1:0] a);
		logic signed [ACC_W:0] v;
		logic signed [ACC_W:0] q;
		v = (ACC_W+1)'(a) + RND;
		q = v >>> COEF_FRAC_BITS;
		if (q > SAT_HI)
			rnd_sat = sample_t'(SAT_HI);
		else if (q < SAT_LO)
			rnd_sat = sample_t'(SAT_LO);
		else
			rnd_sat = sample_t'(q);
	endfunction

	for (genvar k = 0; k < NUM_IN; k++) begin : g_col
		sample_t ar;
		sample_t ai;
		assign ar = sample_t'(coef_re[SAMPLE_W*k +: SAMPLE_W]);
		assign ai = sample_t'(coef_im[SAMPLE_W*k +: SAMPLE_W]);

		always_ff @(posedge clk) begin
			if (en.s2) begin
				prr_s2[k] <= PROD_W'(ar) * PROD_W'(x_s1[k].re);
				pii_s2[k] <= PROD_W'(ai) * PROD_W'(x_s1[k].im);
				pri_s2[k] <= PROD_W'(ar) * PROD_W'(x_s1[k].im);
				pir_s2[k] <= PROD_W'(ai) * PROD_W'(x_s1[k].re);
			end
		end
	end

	always_comb begin
		acc_re = '0;
		acc_im = '0;
		for (int k = 0; k < NUM_IN; k++) begin
			acc_re = acc_re + ACC_W'(prr_s2[k]) - ACC_W'(pii_s2[k]);
			acc_im = acc_im + ACC_W'(pri_s2[k]) + ACC_W'(pir_s2[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			sum_re_s3 <= acc_re;
			sum_im_s3 <= acc_im;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s4) begin
			y_re_s4 <= rnd_sat(sum_re_s3);
			y_im_s4 <= rnd_sat(sum_im_s3);
		end
	end

endmodule

>>> rtl/core/complex_matrix_vector_mixer.sv
// Complex 4x4 matrix times vector, Q1.14 coefficients, 16-bit rounded outputs.
// Throughput: one transaction per cycle unless the output stalls; up to four items in flight in
// input, product, sum and result registers, bubbles close up under stall.
// Reset (arst_n, async, active low) empties the pipeline and loads the
// identity matrix into the coefficient registers.
module complex_matrix_vector_mixer import cmvm_pkg::*; #(
	parameter int NUM_IN         = 4,
	parameter int NUM_OUT        = 4,
	parameter int COEF_FRAC_BITS = 14
) (
	input  logic                 clk,
	input  logic                 arst_n,
	cmvm_in_if.sink              in_ch,
	cmvm_out_if.source           out_ch,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [REG_W-1:0]     cfg_wdata
);

	// Stage valids: s1 input register, s2 products, s3 row sums, s4 result
	logic v_s1, v_s2, v_s3, v_s4;
	logic en_s1;
	pipe_en_t en;

	cvec_t   x_in;
	cvec_t   x_s1;
	logic    be_s1, be_s2, be_s3, be_s4;
	sample_t y_re [NUM_CH];
	sample_t y_im [NUM_CH];

	coef_bank_t coef;

	// A stage loads when it is empty or its contents move on this cycle,
	// so an empty result register never holds back the stages behind it.
	assign en.s4 = !v_s4 || out_ch.ready;
	assign en.s3 = !v_s3 || en.s4;
	assign en.s2 = !v_s2 || en.s3;
	assign en_s1 = !v_s1 || en.s2;

	assign in_ch.ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_ch.valid;
			if (en.s2) v_s2 <= v_s1;
			if (en.s3) v_s3 <= v_s2;
			if (en.s4) v_s4 <= v_s3;
		end
	end

	// Gather the interface fields into a channel vector
	assign x_in[0] = '{re: in_ch.x0_re, im: in_ch.x0_im};
	assign x_in[1] = '{re: in_ch.x1_re, im: in_ch.x1_im};
	assign x_in[2] = '{re: in_ch.x2_re, im: in_ch.x2_im};
	assign x_in[3] = '{re: in_ch.x3_re, im: in_ch.x3_im};

	// Input register; the block end flag rides along the payload stages
	always_ff @(posedge clk) begin
		if (en_s1) begin
			x_s1  <= x_in;
			be_s1 <= in_ch.block_end;
		end
		if (en.s2) be_s2 <= be_s1;
		if (en.s3) be_s3 <= be_s2;
		if (en.s4) be_s4 <= be_s3;
	end

	cmvm_coef_bank u_coef (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.coef      (coef)
	);

	// One datapath row per used output channel; unused channels read zero
	for (genvar r = 0; r < NUM_CH; r++) begin : g_row
		if (r < NUM_OUT) begin : g_used
			cmvm_row #(
				.NUM_IN         (NUM_IN),
				.COEF_FRAC_BITS (COEF_FRAC_BITS)
			) u_row (
				.clk     (clk),
				.en      (en),
				.x_s1    (x_s1),
				.coef_re (coef[2*r]),
				.coef_im (coef[2*r+1]),
				.y_re_s4 (y_re[r]),
				.y_im_s4 (y_im[r])
			);
		end else begin : g_unused
			assign y_re[r] = '0;
			assign y_im[r] = '0;
		end
	end

	assign out_ch.valid         = v_s4;
	assign out_ch.y0_re         = y_re[0];
	assign out_ch.y0_im         = y_im[0];
	assign out_ch.y1_re         = y_re[1];
	assign out_ch.y1_im         = y_im[1];
	assign out_ch.y2_re         = y_re[2];
	assign out_ch.y2_im         = y_im[2];
	assign out_ch.y3_re         = y_re[3];
	assign out_ch.y3_im         = y_im[3];
	assign out_ch.block_end_out = be_s4;

endmodule

>>> rtl/core/cmvm_checker.sv
// Port-level checks for the mixer, attached to the top level by bind.
// Depends on cmvm_pkg for the payload widths.
module cmvm_checker import cmvm_pkg::*; (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [NUM_CH*2*SAMPLE_W:0]   out_data
);

	localparam int DEPTH = 4;

	logic in_xfer;
	logic out_xfer;
	logic [2:0] cnt_q;

	assign in_xfer  = in_valid && in_ready;
	assign out_xfer = out_valid && out_ready;

	// Items accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_q <= '0;
		else
			cnt_q <= cnt_q + 3'(in_xfer) - 3'(out_xfer);
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed or withdrawn while stalled");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with no result pending");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> cnt_q != 3'd0)
		else $error("result offered with no item in flight");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 3'(DEPTH))
		else $error("more items in flight than pipeline stages");

endmodule

bind complex_matrix_vector_mixer cmvm_checker u_cmvm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_data  ({out_ch.y0_re, out_ch.y0_im, out_ch.y1_re, out_ch.y1_im,
		out_ch.y2_re, out_ch.y2_im, out_ch.y3_re, out_ch.y3_im, out_ch.block_end_out})
);

>>> sim/complex_matrix_vector_mixer_tb.sv
// Self-checking testbench for the complex 4x4 matrix-vector mixer.
// Depends on cmvm_pkg, the cmvm_in_if/cmvm_out_if interfaces and the mixer RTL.
// Directed and random transactions are predicted in place and checked in order.
module complex_matrix_vector_mixer_tb;
	import cmvm_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int  FRAC        = 14;
	localparam int  LATENCY     = 3;
	localparam int  CYCLE_LIMIT = 200000;
	localparam int  IDLE_PCT    = 13;
	localparam int  PHASE_ITEMS = 225;

	localparam sample_t S_MAX = 16'sh7FFF;
	localparam sample_t S_MIN = 16'sh8000;

	// Indexes outside the coefficient bank; writes to them must be dropped
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 4'd8;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_TOP   = 4'd15;

	// One sample vector with its block end flag, and one mixed output vector
	typedef struct packed {
		cvec_t x;
		logic  block_end;
	} mix_in_t;

	typedef struct packed {
		cvec_t y;
		logic  block_end;
	} mix_out_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [REG_W-1:0]     cfg_wdata;

	cmvm_in_if  in_ch();
	cmvm_out_if out_ch();

	complex_matrix_vector_mixer #(
		.NUM_IN(NUM_CH),
		.NUM_OUT(NUM_CH),
		.COEF_FRAC_BITS(FRAC)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	// Testbench copy of the coefficient bank, updated on every register write
	coef_bank_t coef_model;
	// Mixed vectors still owed by the block, oldest first
	mix_out_t   pending_mix[$];
	int         mismatches;
	int         cycles;
	// Set during the stretch where neither side is allowed to idle
	bit         no_idle;

	always #10 clk = ~clk;

	// Round half up, drop the fraction bits and clamp to the sample range
	function automatic sample_t round_saturate(longint acc);
		longint q;
		q = (acc + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
		if (q > 32767)
			q = 32767;
		if (q < -32768)
			q = -32768;
		return sample_t'(q);
	endfunction

	// y = A*x over the full complex matrix, exact sums before rounding
	function automatic mix_out_t mix_predict(mix_in_t v);
		mix_out_t res;
		sample_t  c_re;
		sample_t  c_im;
		longint   acc_re;
		longint   acc_im;
		for (int r = 0; r < NUM_CH; r++) begin
			acc_re = 0;
			acc_im = 0;
			for (int k = 0; k < NUM_CH; k++) begin
				c_re = coef_model[2*r][SAMPLE_W*k +: SAMPLE_W];
				c_im = coef_model[2*r+1][SAMPLE_W*k +: SAMPLE_W];
				acc_re += longint'(c_re) * longint'(v.x[k].re)
					- longint'(c_im) * longint'(v.x[k].im);
				acc_im += longint'(c_re) * longint'(v.x[k].im)
					+ longint'(c_im) * longint'(v.x[k].re);
			end
			res.y[r].re = round_saturate(acc_re);
			res.y[r].im = round_saturate(acc_im);
		end
		res.block_end = v.block_end;
		return res;
	endfunction

	// Uniform values half the time, otherwise the range ends, zero and unit steps
	function automatic sample_t pick_sample();
		case ($urandom_range(0, 9))
			0: return S_MAX;
			1: return S_MIN;
			2: return '0;
			3: return sample_t'(1);
			4: return sample_t'(-1);
			default: return sample_t'($urandom);
		endcase
	endfunction

	function automatic mix_in_t uniform_item(sample_t re, sample_t im, logic be);
		mix_in_t v;
		for (int k = 0; k < NUM_CH; k++) begin
			v.x[k].re = re;
			v.x[k].im = im;
		end
		v.block_end = be;
		return v;
	endfunction

	function automatic mix_in_t random_item(bit real_only);
		mix_in_t v;
		for (int k = 0; k < NUM_CH; k++) begin
			v.x[k].re = pick_sample();
			v.x[k].im = real_only ? sample_t'(0) : pick_sample();
		end
		v.block_end = ($urandom_range(0, 7) == 0);
		return v;
	endfunction

	function automatic coef_bank_t fill_matrix(sample_t c);
		coef_bank_t m;
		for (int r = 0; r < NUM_REGS; r++)
			for (int k = 0; k < NUM_CH; k++)
				m[r][SAMPLE_W*k +: SAMPLE_W] = c;
		return m;
	endfunction

	// Imaginary rows are odd register indexes; clear them for real-only mixing
	function automatic coef_bank_t random_matrix(bit real_only);
		coef_bank_t m;
		for (int r = 0; r < NUM_REGS; r++)
			for (int k = 0; k < NUM_CH; k++)
				m[r][SAMPLE_W*k +: SAMPLE_W] = (real_only && r[0]) ? sample_t'(0) : pick_sample();
		return m;
	endfunction

	function automatic coef_bank_t identity_matrix();
		coef_bank_t m;
		m[CFG_ROW0_RE] = RST_ROW0_RE;
		m[CFG_ROW0_IM] = RST_IMAG;
		m[CFG_ROW1_RE] = RST_ROW1_RE;
		m[CFG_ROW1_IM] = RST_IMAG;
		m[CFG_ROW2_RE] = RST_ROW2_RE;
		m[CFG_ROW2_IM] = RST_IMAG;
		m[CFG_ROW3_RE] = RST_ROW3_RE;
		m[CFG_ROW3_IM] = RST_IMAG;
		return m;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("MISMATCH %s: got %0d, expected %0d (t=%0t)", what, got, want, $realtime);
		mismatches++;
	endtask

	// Hold the write strobe for one edge; the caller drops it after its last write
	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		if (idx < NUM_REGS)
			coef_model[idx] = data;
	endtask

	task automatic load_matrix(coef_bank_t m);
		cfg_idx_t r;
		r = r.first();
		repeat (NUM_REGS) begin
			cfg_write(r, m[r]);
			r = r.next();
		end
		cfg_we <= 1'b0;
	endtask

	// Offer one vector, with a random gap first, and book its result on acceptance.
	// Valid stays high on return so back-to-back transactions need no re-raise.
	task automatic send_sample(mix_in_t v);
		while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid     <= 1'b1;
		in_ch.x0_re     <= v.x[0].re;
		in_ch.x0_im     <= v.x[0].im;
		in_ch.x1_re     <= v.x[1].re;
		in_ch.x1_im     <= v.x[1].im;
		in_ch.x2_re     <= v.x[2].re;
		in_ch.x2_im     <= v.x[2].im;
		in_ch.x3_re     <= v.x[3].re;
		in_ch.x3_im     <= v.x[3].im;
		in_ch.block_end <= v.block_end;
		do
			@(posedge clk);
		while (!in_ch.ready);
		pending_mix.push_back(mix_predict(v));
	endtask

	// Drop valid, let every owed result come out, then give the pipe its latency
	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		while (pending_mix.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	// Reset leaves the identity in place: outputs must equal inputs exactly
	task automatic test_identity_passthrough();
		send_sample(uniform_item('0, '0, 1'b0));
		send_sample(uniform_item(S_MAX, S_MAX, 1'b1));
		send_sample(uniform_item(S_MIN, S_MIN, 1'b0));
		send_sample(uniform_item(16'sh5555, 16'shAAAA, 1'b1));
		send_sample(uniform_item(16'shAAAA, 16'sh5555, 1'b0));
		wait_drained();
	endtask

	// Writes above the last coefficient register must leave the bank untouched
	task automatic test_unmapped_index();
		cfg_write(CFG_IDX_SPARE, '1);
		cfg_write(CFG_IDX_TOP, '1);
		cfg_we <= 1'b0;
		send_sample(uniform_item(16'sh1234, -16'sh0F0F, 1'b0));
		send_sample(uniform_item(S_MIN, S_MAX, 1'b1));
		wait_drained();
	endtask

	// Half and one-LSB gains land on rounding ties and just beside them, both signs
	task automatic test_rounding();
		coef_bank_t m;
		mix_in_t    v;
		m = '0;
		m[CFG_ROW0_RE] = 64'h0000_0000_0000_2000;
		m[CFG_ROW1_RE] = 64'h0000_0000_2000_0000;
		m[CFG_ROW2_RE] = 64'h0000_2000_0000_0000;
		m[CFG_ROW3_RE] = 64'h0001_0000_0000_0000;
		load_matrix(m);
		v.x[0].re = sample_t'(1);     v.x[0].im = sample_t'(-1);
		v.x[1].re = sample_t'(3);     v.x[1].im = sample_t'(-3);
		v.x[2].re = sample_t'(5);     v.x[2].im = sample_t'(-5);
		v.x[3].re = sample_t'(8192);  v.x[3].im = sample_t'(-8192);
		v.block_end = 1'b0;
		send_sample(v);
		v.x[3].re = sample_t'(8191);  v.x[3].im = sample_t'(-8193);
		v.block_end = 1'b1;
		send_sample(v);
		wait_drained();
	endtask

	// Largest coefficients against largest samples: every part that overflows must clamp
	task automatic test_saturation();
		load_matrix(fill_matrix(S_MIN));
		send_sample(uniform_item(S_MAX, S_MAX, 1'b0));
		send_sample(uniform_item(S_MIN, S_MIN, 1'b1));
		send_sample(uniform_item(S_MAX, S_MIN, 1'b0));
		wait_drained();
		load_matrix(fill_matrix(S_MAX));
		send_sample(uniform_item(S_MAX, S_MAX, 1'b0));
		send_sample(uniform_item(S_MIN, S_MAX, 1'b1));
		wait_drained();
	endtask

	// Random traffic over several matrices: random, the two extremes, real-only
	// without idling, random with a full drain half-way, and back to identity
	task automatic test_random_mixing();
		for (int phase = 0; phase < 6; phase++) begin
			bit real_only;
			real_only = (phase == 3);
			case (phase)
				1: load_matrix(fill_matrix(S_MAX));
				2: load_matrix(fill_matrix(S_MIN));
				5: load_matrix(identity_matrix());
				default: load_matrix(random_matrix(real_only));
			endcase
			no_idle = (phase == 3);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// Hold the sender until the block has delivered everything owed
				if (phase == 4 && n == PHASE_ITEMS / 2)
					wait_drained();
				send_sample(random_item(real_only));
			end
			wait_drained();
			no_idle = 1'b0;
		end
	endtask

	// Result side: check each accepted vector, then decide ready for the next edge
	always @(posedge clk) begin
		mix_out_t got;
		mix_out_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got.y[0].re    = out_ch.y0_re;
			got.y[0].im    = out_ch.y0_im;
			got.y[1].re    = out_ch.y1_re;
			got.y[1].im    = out_ch.y1_im;
			got.y[2].re    = out_ch.y2_re;
			got.y[2].im    = out_ch.y2_im;
			got.y[3].re    = out_ch.y3_re;
			got.y[3].im    = out_ch.y3_im;
			got.block_end  = out_ch.block_end_out;
			if (pending_mix.size() == 0) begin
				report_mismatch("result with nothing pending", 1, 0);
			end else begin
				want = pending_mix.pop_front();
				for (int k = 0; k < NUM_CH; k++) begin
					if (got.y[k].re !== want.y[k].re)
						report_mismatch($sformatf("y%0d_re", k), got.y[k].re, want.y[k].re);
					if (got.y[k].im !== want.y[k].im)
						report_mismatch($sformatf("y%0d_im", k), got.y[k].im, want.y[k].im);
				end
				if (got.block_end !== want.block_end)
					report_mismatch("block_end_out", got.block_end, want.block_end);
			end
		end
		out_ch.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
	end

	// Watchdog: abandon the run if it hangs
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		clk             = 1'b0;
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = '0;
		cfg_wdata       = '0;
		in_ch.valid     = 1'b0;
		in_ch.x0_re     = '0;
		in_ch.x0_im     = '0;
		in_ch.x1_re     = '0;
		in_ch.x1_im     = '0;
		in_ch.x2_re     = '0;
		in_ch.x2_im     = '0;
		in_ch.x3_re     = '0;
		in_ch.x3_im     = '0;
		in_ch.block_end = 1'b0;
		out_ch.ready    = 1'b0;
		mismatches      = 0;
		cycles          = 0;
		no_idle         = 1'b0;
		coef_model      = identity_matrix();

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_identity_passthrough();
		test_unmapped_index();
		test_rounding();
		test_saturation();
		test_random_mixing();

		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
